// File: hw/rtl/blpd_pkg.sv
// types and constants shared by the bounded list unit and its storage cells
// no dependencies

package blpd_pkg;

    localparam int DATA_W = 32;

    // request command codes
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // result status codes
    localparam logic [2:0] ST_INSERTED  = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_REMOVED   = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_ENTRY     = 3'd4;
    localparam logic [2:0] ST_EMPTY     = 3'd5;

    typedef struct packed {
        logic [1:0]               command;
        logic signed [DATA_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_value;
        logic [2:0]               status;
        logic                     last;
    } result_t;

    // what every cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_SHIFT_BACK,
        CELL_DELETE,
        CELL_ROTATE
    } cell_cmd_t;

    typedef struct packed {
        cell_cmd_t                cmd;
        logic signed [DATA_W-1:0] key;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/blpd_cell.sv
// one storage cell of the list chain: holds one entry and trades it with its neighbors
// depends on blpd_pkg

module blpd_cell
(
    input  logic                               clk,
    input  blpd_pkg::cell_ctrl_t               ctrl,
    input  logic                               occupied,
    input  logic                               tail,
    input  logic                               hit_in,
    input  logic signed [blpd_pkg::DATA_W-1:0] prev_value,
    input  logic signed [blpd_pkg::DATA_W-1:0] next_value,
    input  logic signed [blpd_pkg::DATA_W-1:0] wrap_value,
    output logic                               hit_out,
    output logic signed [blpd_pkg::DATA_W-1:0] value
);

    logic signed [blpd_pkg::DATA_W-1:0] value_reg;
    logic signed [blpd_pkg::DATA_W-1:0] value_next;

    // a hit here or in front means this cell closes the gap
    assign hit_out = hit_in | (occupied && (value_reg == ctrl.key));
    assign value   = value_reg;

    always_comb
    begin
        value_next = value_reg;
        case (ctrl.cmd)
            blpd_pkg::CELL_HOLD:       value_next = value_reg;
            blpd_pkg::CELL_SHIFT_BACK: value_next = prev_value;
            blpd_pkg::CELL_DELETE:
            begin
                if (hit_out)
                begin
                    value_next = next_value;
                end
            end
            blpd_pkg::CELL_ROTATE:
            begin
                // rotate within the occupied part: the tail takes the front entry
                if (tail)
                begin
                    value_next = wrap_value;
                end
                else
                begin
                    value_next = next_value;
                end
            end
            default:                   value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

// File: hw/rtl/bounded_list_push_front_delete_unit.sv
// bounded list unit: controller, entry counter and the chain of storage cells
// depends on blpd_pkg and blpd_cell
//
// usage:
//   a request (command, value) is taken at a rising edge where start is high and
//   busy is low. each result appears on result for exactly one cycle with done
//   high; the receiver cannot hold results off.
//   insert: one result, registered in the cycle after the request (inserted or full).
//   delete: one result, registered in the cycle after the request (removed or not found); all
//     cells compare against the key at once and the first hit cell and the cells behind
//     it take their right neighbor's entry in the same cycle.
//   read: busy stays high while the entries are read out; each cycle the chain rotates
//     by one and the front cell is registered into result, front entry first, the last
//     one marked by result.last. an empty list gives one empty result in the cycle
//     after the request.
//   command three is dropped without a result.
//   insert and delete take one request per cycle; a read holds off requests while busy.
//   reset empties the list; cell contents are not cleared and are never shown
//   before they are written.

module bounded_list_push_front_delete_unit
#(
    parameter int CAPACITY = 16
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  blpd_pkg::request_t request,
    output logic               busy,
    output logic               done,
    output blpd_pkg::result_t  result
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  rd_idx_reg;
    logic              done_reg;
    blpd_pkg::result_t result_reg;

    blpd_pkg::cell_ctrl_t ctrl;
    logic                 accept;
    logic                 full;
    logic                 found;
    logic                 rd_last;

    logic [CAPACITY:0]                  hit;
    logic [CAPACITY-1:0]                occupied;
    logic [CAPACITY-1:0]                tail;
    logic signed [blpd_pkg::DATA_W-1:0] cell_value [CAPACITY];

    assign busy    = (state_reg == ST_READ);
    assign accept  = start && !busy;
    assign full    = (count_reg == CNT_W'(CAPACITY));
    assign found   = hit[CAPACITY];
    assign rd_last = (rd_idx_reg == (count_reg - CNT_W'(1)));
    assign hit[0]  = 1'b0;
    assign done    = done_reg;
    assign result  = result_reg;

    always_comb
    begin
        ctrl.cmd = blpd_pkg::CELL_HOLD;
        ctrl.key = request.value;
        if (state_reg == ST_READ)
        begin
            ctrl.cmd = blpd_pkg::CELL_ROTATE;
        end
        else if (accept)
        begin
            case (request.command)
                blpd_pkg::CMD_INSERT:
                begin
                    if (!full)
                    begin
                        ctrl.cmd = blpd_pkg::CELL_SHIFT_BACK;
                    end
                end
                blpd_pkg::CMD_DELETE: ctrl.cmd = blpd_pkg::CELL_DELETE;
                default:              ctrl.cmd = blpd_pkg::CELL_HOLD;
            endcase
        end
    end

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            logic signed [blpd_pkg::DATA_W-1:0] prev_v;
            logic signed [blpd_pkg::DATA_W-1:0] next_v;

            assign occupied[i] = (count_reg > CNT_W'(i));
            assign tail[i]     = (count_reg == CNT_W'(i + 1));

            if (i == 0)
            begin : g_front
                assign prev_v = request.value;
            end
            else
            begin : g_mid
                assign prev_v = cell_value[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_back
                assign next_v = cell_value[i];
            end
            else
            begin : g_inner
                assign next_v = cell_value[i+1];
            end

            blpd_cell u_cell
            (
                .clk        (clk),
                .ctrl       (ctrl),
                .occupied   (occupied[i]),
                .tail       (tail[i]),
                .hit_in     (hit[i]),
                .prev_value (prev_v),
                .next_value (next_v),
                .wrap_value (cell_value[0]),
                .hit_out    (hit[i+1]),
                .value      (cell_value[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            rd_idx_reg <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        result_reg.result_value <= request.value;
                        result_reg.last         <= 1'b1;
                        case (request.command)
                            blpd_pkg::CMD_INSERT:
                            begin
                                done_reg <= 1'b1;
                                if (full)
                                begin
                                    result_reg.status <= blpd_pkg::ST_FULL;
                                end
                                else
                                begin
                                    result_reg.status <= blpd_pkg::ST_INSERTED;
                                    count_reg         <= count_reg + CNT_W'(1);
                                end
                            end
                            blpd_pkg::CMD_DELETE:
                            begin
                                done_reg <= 1'b1;
                                if (found)
                                begin
                                    result_reg.status <= blpd_pkg::ST_REMOVED;
                                    count_reg         <= count_reg - CNT_W'(1);
                                end
                                else
                                begin
                                    result_reg.status <= blpd_pkg::ST_NOT_FOUND;
                                end
                            end
                            blpd_pkg::CMD_READ:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg                <= 1'b1;
                                    result_reg.result_value <= '0;
                                    result_reg.status       <= blpd_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    state_reg  <= ST_READ;
                                    rd_idx_reg <= '0;
                                end
                            end
                            default:
                            begin
                                done_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    done_reg                <= 1'b1;
                    result_reg.result_value <= cell_value[0];
                    result_reg.status       <= blpd_pkg::ST_ENTRY;
                    result_reg.last         <= rd_last;
                    rd_idx_reg              <= rd_idx_reg + CNT_W'(1);
                    if (rd_last)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_read_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (done && (result.status == blpd_pkg::ST_ENTRY)))
        else $error("readout cycle without an entry result");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (request.command == blpd_pkg::CMD_INSERT) && !full)
        |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("insert did not grow the list");

    a_more_entries: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.last) |-> busy)
        else $error("readout stopped before the last entry");

    a_read_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> (rd_idx_reg < count_reg))
        else $error("readout index past the list end");
`endif

endmodule
